@@ hw/rtl/modular_exponentiation_core_macros.svh @@
// Assertion macros for the modular exponentiation RTL
`ifndef MODULAR_EXPONENTIATION_CORE_MACROS_SVH
`define MODULAR_EXPONENTIATION_CORE_MACROS_SVH

// antecedent holds -> consequent in the same cycle
`define MME_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent holds -> consequent in the next cycle
`define MME_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/mme_pkg.sv @@
// Package for the modular exponentiation core: widths, state type, control structs
`timescale 1ns / 1ps

package mme_pkg;

	localparam int DATA_W            = 64;
	localparam int OPERAND_WIDTH_DEF = 64;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED,
		ST_MUL,
		ST_SQR,
		ST_DONE
	} mme_state_t;

	typedef struct packed {
		logic start;
	} mme_mul_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mme_mul_stat_t;

endpackage

@@ hw/rtl/mme_if.sv @@
// Valid/ready channel interfaces for the modular exponentiation core
`timescale 1ns / 1ps

interface mme_req_if
	import mme_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] base;
	logic [DATA_W-1:0] exponent;
	logic [DATA_W-1:0] modulus;

	modport source (output valid, base, exponent, modulus, input ready);
	modport sink   (input valid, base, exponent, modulus, output ready);
endinterface

interface mme_rsp_if
	import mme_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] power_residue;
	logic              zero_modulus_error;

	modport source (output valid, power_residue, zero_modulus_error, input ready);
	modport sink   (input valid, power_residue, zero_modulus_error, output ready);
endinterface

@@ hw/rtl/mme_modmul.sv @@
// Bit-serial modular multiplier: double-and-add, one multiplier bit per cycle
`timescale 1ns / 1ps

module mme_modmul
	import mme_pkg::*;
#(
	parameter int W = OPERAND_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mme_mul_ctrl_t ctrl,
	output mme_mul_stat_t stat,
	input  logic [W-1:0]  x,
	input  logic [W-1:0]  y,
	input  logic [W-1:0]  n,
	output logic [W-1:0]  prod
);

	localparam int CW = $clog2(W);
	localparam int SW = W + 3;
	localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

	logic [W-1:0]  acc_q, x_q, y_q, n_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [SW-1:0] s0, s1, s2;
	logic [W-1:0]  acc_d;

	// (2*acc + bit*x) mod n, with 2*acc + x < 3n
	always_comb begin
		s0 = {2'b00, acc_q, 1'b0} + {3'b000, (y_q[W-1] ? x_q : '0)};
		s1 = s0 - {3'b000, n_q};
		s2 = s0 - {2'b00, n_q, 1'b0};
		if (!s2[SW-1]) begin
			acc_d = s2[W-1:0];
		end else if (!s1[SW-1]) begin
			acc_d = s1[W-1:0];
		end else begin
			acc_d = s0[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_LAST;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
			n_q   <= n;
		end else if (busy_q) begin
			acc_q <= acc_d;
			y_q   <= {y_q[W-2:0], 1'b0};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign prod      = acc_q;

endmodule

@@ hw/rtl/modular_exponentiation_core.sv @@
// Zero modulus, modulus of one or zero exponent go from accept straight to ST_DONE, which loads the
// result register once it is free. Otherwise one base reduction plus a multiply per set exponent
// bit and a square per bit below the top set bit, each product formed in the shared bit-serial
// unit. One word in flight; next accepted once idle.
// Reset (arst_n low, asynchronous) clears the sequencer and output valid; no clearing pass.
`timescale 1ns / 1ps

module modular_exponentiation_core
	import mme_pkg::*;
#(
	parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	mme_req_if.sink   req,
	mme_rsp_if.source rsp
);

	`include "modular_exponentiation_core_macros.svh"

	localparam int W = OPERAND_WIDTH;

	mme_state_t    state_q, state_d;
	mme_mul_ctrl_t mm_ctrl;
	mme_mul_stat_t mm_stat;
	logic          go_q, go_d;
	logic          accept, out_load;
	logic [W-1:0]  base_q, exp_q, mod_q, sq_q, res_q, pres_q;
	logic [W-1:0]  in_base, in_exp, in_mod;
	logic [W-1:0]  mm_x, mm_y, mm_prod;
	logic          err_q, perr_q, ovalid_q;

	assign in_base = req.base[W-1:0];
	assign in_exp  = req.exponent[W-1:0];
	assign in_mod  = req.modulus[W-1:0];

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_load  = (state_q == ST_DONE) && (!ovalid_q || rsp.ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_mod == '0 || in_mod == W'(1) || in_exp == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_RED;
					end
				end
			end
			ST_RED: begin
				if (mm_stat.done) begin
					state_d = exp_q[0] ? ST_MUL : ST_SQR;
				end
			end
			ST_MUL: begin
				if (mm_stat.done) begin
					state_d = (exp_q[W-1:1] == '0) ? ST_DONE : ST_SQR;
				end
			end
			ST_SQR: begin
				if (mm_stat.done) begin
					state_d = exp_q[1] ? ST_MUL : ST_SQR;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		go_d = (state_d == ST_RED || state_d == ST_MUL || state_d == ST_SQR)
			&& (state_q == ST_IDLE || mm_stat.done);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			go_q     <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			go_q    <= go_d;
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					base_q <= in_base;
					exp_q  <= in_exp;
					mod_q  <= in_mod;
					err_q  <= (in_mod == '0);
					res_q  <= (in_mod == '0 || in_mod == W'(1)) ? '0 : W'(1);
				end
			end
			ST_RED: begin
				if (mm_stat.done) begin
					sq_q <= mm_prod;
				end
			end
			ST_MUL: begin
				if (mm_stat.done) begin
					res_q <= mm_prod;
				end
			end
			ST_SQR: begin
				if (mm_stat.done) begin
					sq_q  <= mm_prod;
					exp_q <= {1'b0, exp_q[W-1:1]};
				end
			end
			default: ;
		endcase
		if (out_load) begin
			pres_q <= res_q;
			perr_q <= err_q;
		end
	end

	// base mod n is formed as 1 * base through the same unit
	always_comb begin
		case (state_q)
			ST_RED: begin
				mm_x = W'(1);
				mm_y = base_q;
			end
			ST_MUL: begin
				mm_x = sq_q;
				mm_y = res_q;
			end
			default: begin
				mm_x = sq_q;
				mm_y = sq_q;
			end
		endcase
	end

	assign mm_ctrl.start = go_q;

	mme_modmul #(
		.W(W)
	) u_modmul (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (mm_ctrl),
		.stat  (mm_stat),
		.x     (mm_x),
		.y     (mm_y),
		.n     (mod_q),
		.prod  (mm_prod)
	);

	assign rsp.valid              = ovalid_q;
	assign rsp.power_residue      = DATA_W'(pres_q);
	assign rsp.zero_modulus_error = perr_q;

	`MME_ASSERT_NOW(a_err_zero, rsp.valid && rsp.zero_modulus_error, rsp.power_residue == '0, "error word with nonzero residue")
	`MME_ASSERT_NOW(a_start_idle_unit, mm_ctrl.start, !mm_stat.busy, "multiplier restarted while busy")
	`MME_ASSERT_NOW(a_done_in_op, mm_stat.done, state_q == ST_RED || state_q == ST_MUL || state_q == ST_SQR, "product outside an operation state")
	`MME_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != ST_IDLE, "accepted word left sequencer idle")

endmodule

@@ test/tb_modular_exponentiation_core.sv @@
`timescale 1ns / 1ps

// Testbench for modular_exponentiation_core: directed and random words checked against a wide-product model
module tb_modular_exponentiation_core;
	import mme_pkg::*;

	localparam int OPW = OPERAND_WIDTH_DEF;
	localparam logic [DATA_W-1:0] OP_MASK = {DATA_W{1'b1}} >> (DATA_W - OPW);
	localparam logic [DATA_W-1:0] ALL_ONES = '1;
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int WORDS_PER_PHASE = 20;

	typedef struct packed {
		logic [DATA_W-1:0] base;
		logic [DATA_W-1:0] exponent;
		logic [DATA_W-1:0] modulus;
	} operands_t;

	typedef struct packed {
		logic [DATA_W-1:0] power_residue;
		logic              zero_modulus_error;
	} residue_t;

	logic      clk = 1'b0;
	logic      arst_n;
	operands_t pending_words[$];
	residue_t  expected_residues[$];
	residue_t  want_residue;
	int        sender_idle_pct;
	int        sink_stall_pct;
	int        mismatches = 0;
	int        cycles = 0;

	mme_req_if req_ch();
	mme_rsp_if rsp_ch();

	modular_exponentiation_core dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch.sink),
		.rsp   (rsp_ch.source)
	);

	always #5 clk = ~clk;

	function automatic logic [DATA_W-1:0] mod_product(input logic [DATA_W-1:0] a, b, n);
		logic [2*DATA_W-1:0] wide;
		wide = {{DATA_W{1'b0}}, a} * {{DATA_W{1'b0}}, b};
		wide = wide % {{DATA_W{1'b0}}, n};
		return wide[DATA_W-1:0];
	endfunction

	function automatic residue_t predict_power(input operands_t w);
		logic [DATA_W-1:0] b, e, n, acc, sq;
		residue_t r;
		b = w.base & OP_MASK;
		e = w.exponent & OP_MASK;
		n = w.modulus & OP_MASK;
		r.zero_modulus_error = (n == '0);
		acc = 1;
		if (n == '0 || n == 1) begin
			acc = '0;
		end else begin
			sq = b % n;
			for (int i = 0; i < OPW; i++) begin
				if (e[i])
					acc = mod_product(acc, sq, n);
				sq = mod_product(sq, sq, n);
			end
		end
		r.power_residue = acc & OP_MASK;
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] rand_bits(input int len);
		logic [63:0] v;
		v = {$urandom, $urandom};
		return (len <= 0) ? '0 : v >> (64 - len);
	endfunction

	function automatic operands_t random_word();
		operands_t w;
		case ($urandom_range(0, 19))
			0: w.modulus = '0;
			1: w.modulus = 1;
			2: w.modulus = 2;
			3: w.modulus = ALL_ONES;
			default: w.modulus = rand_bits($urandom_range(2, 64));
		endcase
		case ($urandom_range(0, 9))
			0: w.base = '0;
			1: w.base = ALL_ONES;
			2, 3, 4: w.base = rand_bits(64);
			default: w.base = rand_bits($urandom_range(1, 64));
		endcase
		// short exponents keep most words quick; full width ones still reach the top bits
		case ($urandom_range(0, 19))
			0: w.exponent = '0;
			1, 2, 3, 4: w.exponent = rand_bits(64);
			default: w.exponent = rand_bits($urandom_range(1, 64));
		endcase
		return w;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("%0t mismatch: %0s", $time, msg);
		mismatches++;
	endtask

	task automatic add_word(input logic [DATA_W-1:0] b, e, m);
		pending_words.push_back(operands_t'{b, e, m});
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0 || req_ch.valid || expected_residues.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct);
		sender_idle_pct = idle_pct;
		sink_stall_pct  = stall_pct;
		repeat (WORDS_PER_PHASE)
			pending_words.push_back(random_word());
		wait_drained();
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid    <= 1'b0;
			req_ch.base     <= '0;
			req_ch.exponent <= '0;
			req_ch.modulus  <= '0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (pending_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
				req_ch.valid    <= 1'b1;
				req_ch.base     <= pending_words[0].base;
				req_ch.exponent <= pending_words[0].exponent;
				req_ch.modulus  <= pending_words[0].modulus;
				void'(pending_words.pop_front());
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			expected_residues.push_back(predict_power(
				operands_t'{req_ch.base, req_ch.exponent, req_ch.modulus}));
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_residues.size() == 0) begin
				flag_mismatch($sformatf("unexpected word, residue %h error %b",
					rsp_ch.power_residue, rsp_ch.zero_modulus_error));
			end else begin
				want_residue = expected_residues.pop_front();
				if (rsp_ch.power_residue !== want_residue.power_residue)
					flag_mismatch($sformatf("power_residue got %h want %h",
						rsp_ch.power_residue, want_residue.power_residue));
				if (rsp_ch.zero_modulus_error !== want_residue.zero_modulus_error)
					flag_mismatch($sformatf("zero_modulus_error got %b want %b",
						rsp_ch.zero_modulus_error, want_residue.zero_modulus_error));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		sender_idle_pct = 0;
		sink_stall_pct  = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero modulus
		add_word('0, '0, '0);
		add_word(ALL_ONES, ALL_ONES, '0);
		// modulus of one, also over a zero exponent
		add_word('0, '0, 1);
		add_word(ALL_ONES, ALL_ONES, 1);
		add_word(5, 3, 1);
		// zero exponent, zero base, modulus of two
		add_word('0, '0, 13);
		add_word(ALL_ONES, '0, ALL_ONES);
		add_word(12345, '0, 2);
		add_word('0, 5, 97);
		add_word(ALL_ONES, ALL_ONES, 2);
		add_word(2, 1, 2);
		// base both above and below the modulus
		add_word(1000, 3, 7);
		add_word(ALL_ONES, 2, ALL_ONES - 1);
		add_word(ALL_ONES - 1, ALL_ONES, ALL_ONES);
		add_word(2, 64, ALL_ONES);
		add_word(2, 10, 1000);
		add_word(3, ALL_ONES, 64'h8000_0000_0000_0001);
		add_word(ALL_ONES, ALL_ONES, 64'hFFFF_FFFF_FFFF_FFC5);
		add_word(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 64'hFFFF_FFFF_0000_0001);
		add_word(1, ALL_ONES, 97);
		wait_drained();

		run_phase(0, 0);
		run_phase(60, 0);
		run_phase(0, 60);
		run_phase(19, 19);

		repeat (40) @(posedge clk);
		if (expected_residues.size() != 0)
			flag_mismatch($sformatf("%0d words never returned", expected_residues.size()));
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
